// ===== rtl/core/bfd_pkg.sv =====
// shared types, codes and field widths of the byte ring fifo with separator search
package bfd_pkg;

    // fixed field widths
    localparam int BYTE_W  = 8;
    localparam int CMD_W   = 2;
    localparam int CNT_W   = 5;
    localparam int STAT_W  = 2;
    localparam int FILL_W  = 11;
    localparam int FOUND_W = 11;
    localparam int SEP_W   = 64;
    localparam int SLEN_W  = 4;
    localparam int KIDX_W  = 3;
    localparam int CFGI_W  = 2;

    // stream packing
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = BYTE_W + STAT_W + FILL_W + FOUND_W;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FIND  = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_SEP_BYTES = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_SEP_LEN   = 2'd1;

    // output payload selection
    localparam logic [1:0] OUT_PLAIN = 2'd0;
    localparam logic [1:0] OUT_POP   = 2'd1;
    localparam logic [1:0] OUT_FIND  = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic              push;
        logic              clear;
        logic              rd_start;
        logic              pop;
        logic              fd_start;
        logic              fd_next_k;
        logic              fd_next_i;
        logic              fd_addr;
        logic              out_load;
        logic [1:0]        out_sel;
        logic [STAT_W-1:0] out_status;
        logic              out_last;
    } t_ctl;

    // status from datapath to controller
    typedef struct packed {
        logic empty;
        logic full;
        logic cnt_zero;
        logic remain_last;
        logic sep_bad;
        logic match;
        logic k_last;
        logic i_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/bfd_dp.sv =====
// datapath: byte store, pointers, separator registers, scan indexes and result register
module bfd_dp import bfd_pkg::*; #(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 16,
    parameter int MAX_SEP  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctl                  i_ctl,
    output t_sts                  o_sts,
    input  logic [BYTE_W-1:0]     i_data_in,
    input  logic [CNT_W-1:0]      i_count,
    input  logic                  i_cfg_valid,
    input  logic [CFGI_W-1:0]     i_cfg_index,
    input  logic [SEP_W-1:0]      i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic                  o_out_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int PW = AW + 1;
    localparam int RW = $clog2(MAX_READ + 1);
    localparam int HW = (PW > FILL_W) ? PW : FILL_W;
    localparam int CW = (PW > 7) ? PW : 7;

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    logic [PW-1:0]     r_wptr, n_wptr;
    logic [PW-1:0]     r_rptr, n_rptr;
    logic [RW-1:0]     r_remain;
    logic [PW-1:0]     r_i;
    logic [KIDX_W-1:0] r_k;
    logic [SEP_W-1:0]  r_sep_bytes;
    logic [SLEN_W-1:0] r_sep_len;

    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_out_byte;
    logic [STAT_W-1:0]     r_out_status;
    logic [FILL_W-1:0]     r_out_fill;
    logic [FOUND_W-1:0]    r_out_found;
    logic                  r_out_last;

    logic [PW-1:0]     v_held;
    logic [PW-1:0]     v_held_n;
    logic [HW-1:0]     v_held_x;
    logic [HW-1:0]     v_found_x;
    logic [SLEN_W-1:0] v_len;
    logic [AW-1:0]     v_addr;
    logic [CW-1:0]     v_cnt;
    logic [BYTE_W-1:0] v_want;

    // fill level and effective separator length
    assign v_held = r_wptr - r_rptr;
    assign v_len  = (r_sep_len > SLEN_W'(MAX_SEP)) ? SLEN_W'(MAX_SEP) : r_sep_len;
    assign v_want = r_sep_bytes[BYTE_W*r_k +: BYTE_W];

    // read address: head, or head plus scan offset while searching
    assign v_addr = r_rptr[AW-1:0] + (i_ctl.fd_addr ? (r_i[AW-1:0] + AW'(r_k)) : '0);

    // bytes to pop: count saturated to the read limit and the fill level
    always_comb begin
        v_cnt = CW'(i_count);
        if (v_cnt > CW'(MAX_READ)) begin
            v_cnt = CW'(MAX_READ);
        end
        if (v_cnt > CW'(v_held)) begin
            v_cnt = CW'(v_held);
        end
    end

    // next pointers
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (i_ctl.push) begin
            n_wptr = r_wptr + PW'(1);
        end
        if (i_ctl.clear) begin
            n_rptr = r_wptr;
        end else if (i_ctl.pop) begin
            n_rptr = r_rptr + PW'(1);
        end
    end

    assign v_held_n  = n_wptr - n_rptr;
    assign v_held_x  = HW'(v_held_n);
    assign v_found_x = HW'(r_i) + HW'(v_len);

    // status to the controller
    always_comb begin
        o_sts.empty       = (v_held == '0);
        o_sts.full        = v_held[PW-1];
        o_sts.cnt_zero    = (i_count == '0);
        o_sts.remain_last = (r_remain == RW'(1));
        o_sts.sep_bad     = (v_len == '0) || (v_held < PW'(v_len));
        o_sts.match       = (r_rdata == v_want);
        o_sts.k_last      = ({1'b0, r_k} == (v_len - SLEN_W'(1)));
        o_sts.i_last      = (r_i == (v_held - PW'(v_len)));
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    // byte store with registered read port
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wptr[AW-1:0]] <= i_data_in;
        end
        r_rdata <= r_mem[v_addr];
    end

    // pointers, pop counter, configuration and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_remain    <= '0;
            r_sep_bytes <= SEP_W'(2573);
            r_sep_len   <= SLEN_W'(2);
            r_out_valid <= 1'b0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            if (i_ctl.rd_start) begin
                r_remain <= v_cnt[RW-1:0];
            end else if (i_ctl.pop) begin
                r_remain <= r_remain - RW'(1);
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_SEP_BYTES: r_sep_bytes <= i_cfg_data;
                    CFG_SEP_LEN:   r_sep_len   <= i_cfg_data[SLEN_W-1:0];
                    default: ;
                endcase
            end
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan indexes
    always_ff @(posedge i_clk) begin
        if (i_ctl.fd_start) begin
            r_i <= '0;
            r_k <= '0;
        end else if (i_ctl.fd_next_k) begin
            r_k <= r_k + KIDX_W'(1);
        end else if (i_ctl.fd_next_i) begin
            r_i <= r_i + PW'(1);
            r_k <= '0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load) begin
            r_out_byte   <= (i_ctl.out_sel == OUT_POP) ? r_rdata : '0;
            r_out_status <= i_ctl.out_status;
            r_out_fill   <= v_held_x[FILL_W-1:0];
            r_out_found  <= (i_ctl.out_sel == OUT_FIND) ? v_found_x[FOUND_W-1:0] : '0;
            r_out_last   <= i_ctl.out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_out_found, r_out_fill, r_out_status, r_out_byte};
    assign o_out_last  = r_out_last;

endmodule

// ===== rtl/core/bfd_ctrl.sv =====
// controller: sequences write, read, clear and separator search transactions
module bfd_ctrl import bfd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_command,
    input  t_sts             i_sts,
    output logic             o_in_ready,
    output t_ctl             o_ctl
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RD_ADDR = 3'd1;
    localparam logic [2:0] S_RD_DATA = 3'd2;
    localparam logic [2:0] S_FD_ADDR = 3'd3;
    localparam logic [2:0] S_FD_CMP  = 3'd4;

    logic [2:0] r_state, n_state;

    // new transactions only in idle with room in the result register
    assign o_in_ready = (r_state == S_IDLE) && i_sts.out_free;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ctl.out_sel    = OUT_PLAIN;
        o_ctl.out_status = STAT_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.out_free) begin
                    unique case (i_command)
                        CMD_WRITE: begin
                            o_ctl.out_load = 1'b1;
                            o_ctl.out_last = 1'b1;
                            if (i_sts.full) begin
                                o_ctl.out_status = STAT_FULL;
                            end else begin
                                o_ctl.push = 1'b1;
                            end
                        end
                        CMD_READ: begin
                            if (i_sts.empty) begin
                                o_ctl.out_load   = 1'b1;
                                o_ctl.out_last   = 1'b1;
                                o_ctl.out_status = STAT_EMPTY;
                            end else if (i_sts.cnt_zero) begin
                                o_ctl.out_load = 1'b1;
                                o_ctl.out_last = 1'b1;
                            end else begin
                                o_ctl.rd_start = 1'b1;
                                n_state        = S_RD_ADDR;
                            end
                        end
                        CMD_CLEAR: begin
                            o_ctl.clear    = 1'b1;
                            o_ctl.out_load = 1'b1;
                            o_ctl.out_last = 1'b1;
                        end
                        CMD_FIND: begin
                            if (i_sts.sep_bad) begin
                                o_ctl.out_load = 1'b1;
                                o_ctl.out_last = 1'b1;
                            end else begin
                                o_ctl.fd_start = 1'b1;
                                n_state        = S_FD_ADDR;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // wait for the head byte to come out of the store
            S_RD_ADDR: begin
                n_state = S_RD_DATA;
            end
            S_RD_DATA: begin
                if (i_sts.out_free) begin
                    o_ctl.pop      = 1'b1;
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_sel  = OUT_POP;
                    o_ctl.out_last = i_sts.remain_last;
                    n_state        = i_sts.remain_last ? S_IDLE : S_RD_ADDR;
                end
            end
            S_FD_ADDR: begin
                o_ctl.fd_addr = 1'b1;
                n_state       = S_FD_CMP;
            end
            // compare one stored byte against one separator byte
            S_FD_CMP: begin
                o_ctl.fd_addr = 1'b1;
                if (i_sts.match && !i_sts.k_last) begin
                    o_ctl.fd_next_k = 1'b1;
                    n_state         = S_FD_ADDR;
                end else if (!i_sts.match && !i_sts.i_last) begin
                    o_ctl.fd_next_i = 1'b1;
                    n_state         = S_FD_ADDR;
                end else if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    o_ctl.out_last = 1'b1;
                    o_ctl.out_sel  = i_sts.match ? OUT_FIND : OUT_PLAIN;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/byte_ring_fifo_delim_search.sv =====
// top level of the byte ring fifo with separator search
// Byte FIFO of DEPTH bytes (a power of two) with a command stream on tuser and one result
// per command, or one per popped byte on a read. Write, clear, and reads that find the FIFO
// empty or ask for zero bytes are answered straight from idle while results are drained.
// A read pops one byte at a time, each waiting on the registered read port of the byte
// store and on room in the result register. A search compares one stored byte with one
// separator byte at a time over the same port; input is held off meanwhile.
// The byte store is not cleared after reset; only bytes that were written are ever read.
// Configuration writes are taken at once and must come while the block is idle.
module byte_ring_fifo_delim_search import bfd_pkg::*; #(
    parameter int DEPTH    = 1024,
    parameter int MAX_READ = 16,
    parameter int MAX_SEP  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // data_in[7:0], count[12:8], zero[15:13]
    input  logic [CMD_W-1:0]      i_s_axis_tuser,   // command[1:0]
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // data_out[7:0], status[9:8],
                                                    // fill_level[20:10], found_end[31:21]
    output logic                  o_m_axis_tlast,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFGI_W-1:0]     i_cfg_index,
    input  logic [SEP_W-1:0]      i_cfg_data
);

    t_ctl w_ctl;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    // sequencing
    bfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_command  (i_s_axis_tuser),
        .i_sts      (w_sts),
        .o_in_ready (o_s_axis_tready),
        .o_ctl      (w_ctl)
    );

    // storage and result path
    bfd_dp #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ),
        .MAX_SEP  (MAX_SEP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .i_data_in   (i_s_axis_tdata[BYTE_W-1:0]),
        .i_count     (i_s_axis_tdata[BYTE_W +: CNT_W]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule

// ===== rtl/core/bfd_checker.sv =====
// port-level checks on the result stream of the byte ring fifo, bound to the top level
module bfd_checker import bfd_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  o_m_axis_tlast
);

    logic [BYTE_W-1:0]  w_byte;
    logic [STAT_W-1:0]  w_status;
    logic [FILL_W-1:0]  w_fill;
    logic [FOUND_W-1:0] w_found;

    assign w_byte   = o_m_axis_tdata[BYTE_W-1:0];
    assign w_status = o_m_axis_tdata[BYTE_W +: STAT_W];
    assign w_fill   = o_m_axis_tdata[BYTE_W+STAT_W +: FILL_W];
    assign w_found  = o_m_axis_tdata[BYTE_W+STAT_W+FILL_W +: FOUND_W];

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

    // an empty read reports an empty fifo and ends its transaction
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_status == STAT_EMPTY) |->
            (w_fill == '0) && o_m_axis_tlast && (w_byte == '0))
        else $error("empty read result malformed");

    // only multi-byte reads leave tlast low, and they are plain pops
    a_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |->
            (w_status == STAT_OK) && (w_found == '0))
        else $error("non-final result is not a pop");

    // a search hit is a single clean result
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (w_found != '0) |->
            (w_status == STAT_OK) && o_m_axis_tlast && (w_byte == '0))
        else $error("search result malformed");

endmodule

bind byte_ring_fifo_delim_search bfd_checker u_bfd_checker (.*);

// ===== sim/byte_ring_fifo_delim_search_tb.sv =====
`timescale 1ns / 1ps
// testbench for the byte ring fifo with separator search: predicted results vs streamed results
module byte_ring_fifo_delim_search_tb;
    import bfd_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int MAX_READ   = 16;
    localparam int MAX_SEP    = 8;
    localparam int STALL_LIMIT = 100000;

    // one predicted result transaction
    typedef struct packed {
        logic [BYTE_W-1:0]  data_out;
        logic [STAT_W-1:0]  status;
        logic [FILL_W-1:0]  fill_level;
        logic [FOUND_W-1:0] found_end;
        logic               last;
    } t_fifo_result;

    // mirror of the fifo contents, pointers and separator setup
    class fifo_result_board;
        logic [BYTE_W-1:0] store [DEPTH];
        logic [FILL_W-1:0] rd_ptr;
        logic [FILL_W-1:0] wr_ptr;
        logic [SEP_W-1:0]  sep;
        logic [SLEN_W-1:0] sep_len;
        t_fifo_result      awaited_results [$];
        int unsigned       mismatches;

        function new();
            rd_ptr     = '0;
            wr_ptr     = '0;
            sep        = 64'd2573;
            sep_len    = 4'd2;
            mismatches = 0;
        endfunction

        function int unsigned held();
            logic [FILL_W-1:0] diff;
            diff = wr_ptr - rd_ptr;
            return diff;
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        function void apply_register(logic [CFGI_W-1:0] idx, logic [SEP_W-1:0] val);
            if (idx == CFG_SEP_BYTES) sep = val;
            else if (idx == CFG_SEP_LEN) sep_len = val[SLEN_W-1:0];
        endfunction

        function void await_result(logic [BYTE_W-1:0] d, logic [STAT_W-1:0] st,
                                   int unsigned found, logic lst);
            t_fifo_result r;
            r.data_out   = d;
            r.status     = st;
            r.fill_level = FILL_W'(held());
            r.found_end  = FOUND_W'(found);
            r.last       = lst;
            awaited_results.push_back(r);
        endfunction

        // offset just past the first separator match from the read pointer, 0 if none
        function int unsigned scan_for_separator();
            int unsigned len;
            int unsigned used;
            int unsigned i;
            int unsigned k;
            bit hit;
            len  = (sep_len > MAX_SEP) ? MAX_SEP : sep_len;
            used = held();
            if (len == 0 || used < len) return 0;
            for (i = 0; i <= used - len; i++) begin
                hit = 1'b1;
                for (k = 0; k < len && hit; k++) begin
                    if (store[(rd_ptr + i + k) % DEPTH] != sep[8*k +: 8]) hit = 1'b0;
                end
                if (hit) return i + len;
            end
            return 0;
        endfunction

        // accepted command transaction: update the mirror and queue its results
        function void note_command(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] din,
                                   logic [CNT_W-1:0] cnt);
            int unsigned n;
            int unsigned k;
            logic [BYTE_W-1:0] b;
            case (cmd)
                CMD_WRITE: begin
                    if (held() >= DEPTH) begin
                        await_result('0, STAT_FULL, 0, 1'b1);
                    end else begin
                        store[wr_ptr % DEPTH] = din;
                        wr_ptr = wr_ptr + 1'b1;
                        await_result('0, STAT_OK, 0, 1'b1);
                    end
                end
                CMD_READ: begin
                    if (held() == 0) begin
                        await_result('0, STAT_EMPTY, 0, 1'b1);
                    end else if (cnt == 0) begin
                        await_result('0, STAT_OK, 0, 1'b1);
                    end else begin
                        n = (cnt > MAX_READ) ? MAX_READ : cnt;
                        if (n > held()) n = held();
                        for (k = 0; k < n; k++) begin
                            b = store[rd_ptr % DEPTH];
                            rd_ptr = rd_ptr + 1'b1;
                            await_result(b, STAT_OK, 0, k + 1 == n);
                        end
                    end
                end
                CMD_CLEAR: begin
                    rd_ptr = wr_ptr;
                    await_result('0, STAT_OK, 0, 1'b1);
                end
                default: begin
                    await_result('0, STAT_OK, scan_for_separator(), 1'b1);
                end
            endcase
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in %s: expected %0d, got %0d", field, want, got);
            end
        endfunction

        // accepted result transaction against the oldest prediction
        function void check_result(logic [OUT_DATA_W-1:0] beat, logic tlast);
            t_fifo_result want;
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing awaited: tdata %h tlast %0d", beat, tlast);
                return;
            end
            want = awaited_results.pop_front();
            compare_field("data_out", 32'(want.data_out), 32'(beat[7:0]));
            compare_field("status", 32'(want.status), 32'(beat[9:8]));
            compare_field("fill_level", 32'(want.fill_level), 32'(beat[20:10]));
            compare_field("found_end", 32'(want.found_end), 32'(beat[31:21]));
            compare_field("last", 32'(want.last), 32'(tlast));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [CMD_W-1:0]      i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFGI_W-1:0]     i_cfg_index = '0;
    logic [SEP_W-1:0]      i_cfg_data = '0;

    fifo_result_board board;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_idle_pct = 0;
    int unsigned      stall_cycles = 0;

    byte_ring_fifo_delim_search #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ),
        .MAX_SEP  (MAX_SEP)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: check each transaction, then pick the next ready at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                board.check_result(o_m_axis_tdata, o_m_axis_tlast);
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // cycles since the last transaction on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // one command transaction, with a random gap ahead of it
    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] din,
                         input logic [CNT_W-1:0] cnt);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, cnt, din};
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        board.note_command(cmd, din, cnt);
    endtask

    // stop sending and let every awaited result drain
    task automatic wait_quiet();
        i_s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one register write, then the configuration channel goes idle
    task automatic write_register(input logic [CFGI_W-1:0] idx, input logic [SEP_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.apply_register(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // random traffic, mostly messages that end in the separator
    task automatic random_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned pick;
        int unsigned body;
        int unsigned slen;
        int unsigned k;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            slen = (board.sep_len > MAX_SEP) ? MAX_SEP : board.sep_len;
            if (board.held() > 48 && pick < 40) pick = 50;
            if (pick < 40) begin
                body = $urandom_range(0, 6);
                for (k = 0; k < body; k++)
                    issue(CMD_WRITE, BYTE_W'($urandom_range(0, 255)),
                          CNT_W'($urandom_range(0, 31)));
                // separator, cut short now and then
                if (slen != 0 && $urandom_range(0, 3) == 0) slen = $urandom_range(1, slen);
                for (k = 0; k < slen; k++)
                    issue(CMD_WRITE, board.sep[8*k +: 8], CNT_W'($urandom_range(0, 31)));
                sent += body + slen;
            end else begin
                if (pick < 65)
                    issue(CMD_READ, BYTE_W'($urandom_range(0, 255)),
                          CNT_W'($urandom_range(0, 31)));
                else if (pick < 82)
                    issue(CMD_FIND, BYTE_W'($urandom_range(0, 255)),
                          CNT_W'($urandom_range(0, 31)));
                else if (pick < 88)
                    issue(CMD_CLEAR, BYTE_W'($urandom_range(0, 255)),
                          CNT_W'($urandom_range(0, 31)));
                else
                    issue(CMD_WRITE, BYTE_W'($urandom_range(0, 255)),
                          CNT_W'($urandom_range(0, 31)));
                sent++;
            end
        end
    endtask

    initial begin
        int unsigned k;
        board = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles 28%, receiver 70%
        send_idle_pct = 28;
        recv_idle_pct = 70;

        // directed commands with the reset separator (CR LF)
        issue(CMD_READ, 8'h00, 5'd1);
        issue(CMD_FIND, 8'h00, 5'd0);
        issue(CMD_READ, 8'h00, 5'd0);
        issue(CMD_WRITE, 8'h0D, 5'd0);
        issue(CMD_FIND, 8'h00, 5'd0);
        issue(CMD_WRITE, 8'h0A, 5'd0);
        issue(CMD_FIND, 8'h00, 5'd0);
        issue(CMD_WRITE, 8'h00, 5'd0);
        issue(CMD_WRITE, 8'hFF, 5'd31);
        issue(CMD_READ, 8'hFF, 5'd0);
        issue(CMD_FIND, 8'hFF, 5'd31);
        issue(CMD_READ, 8'h00, 5'd31);
        issue(CMD_READ, 8'h00, 5'd16);
        issue(CMD_WRITE, 8'h41, 5'd1);
        issue(CMD_WRITE, 8'h0D, 5'd1);
        issue(CMD_WRITE, 8'h0D, 5'd1);
        issue(CMD_WRITE, 8'h0A, 5'd1);
        issue(CMD_FIND, 8'h00, 5'd0);
        issue(CMD_CLEAR, 8'h00, 5'd0);
        issue(CMD_FIND, 8'h00, 5'd0);
        issue(CMD_READ, 8'h00, 5'd1);
        issue(CMD_WRITE, 8'h5A, 5'd0);
        issue(CMD_READ, 8'h00, 5'd1);
        issue(CMD_CLEAR, 8'h00, 5'd0);
        wait_quiet();

        // indexes past the register list are ignored
        write_register(2'd2, {$urandom, $urandom});
        write_register(2'd3, {$urandom, $urandom});
        write_register(CFG_SEP_BYTES, {$urandom, $urandom});
        write_register(CFG_SEP_LEN, 64'd3);
        random_traffic(30);
        wait_quiet();

        // sender idles 70%, receiver 28%
        send_idle_pct = 70;
        recv_idle_pct = 28;

        // zero separator length never matches
        write_register(CFG_SEP_LEN, 64'd0);
        issue(CMD_WRITE, board.sep[7:0], 5'd0);
        issue(CMD_WRITE, board.sep[15:8], 5'd0);
        issue(CMD_FIND, 8'h00, 5'd0);
        issue(CMD_CLEAR, 8'h00, 5'd0);
        wait_quiet();

        // length above the maximum saturates
        write_register(CFG_SEP_BYTES, {$urandom, $urandom});
        write_register(CFG_SEP_LEN, 64'd15);
        random_traffic(30);
        wait_quiet();

        // no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // full-length all-ones separator at the end of the stored bytes
        write_register(CFG_SEP_BYTES, '1);
        write_register(CFG_SEP_LEN, 64'd8);
        issue(CMD_CLEAR, 8'h00, 5'd0);
        for (k = 0; k < 20; k++)
            issue(CMD_WRITE, BYTE_W'($urandom_range(0, 254)), CNT_W'($urandom_range(0, 31)));
        for (k = 0; k < MAX_SEP; k++) issue(CMD_WRITE, 8'hFF, 5'd0);
        issue(CMD_FIND, 8'h00, 5'd0);
        // drain it, ending on an empty read
        for (k = 0; k < 3; k++) issue(CMD_READ, 8'h00, 5'd16);
        wait_quiet();

        // single zero-byte separator
        write_register(CFG_SEP_BYTES, '0);
        write_register(CFG_SEP_LEN, 64'd1);
        random_traffic(30);
        wait_quiet();
        repeat (20) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
